@@ src/tpd_pkg.sv @@
// Package for the thermal packet deframer: shared widths, default
// parameter values, result codes, register indexes and beat types.
// No dependencies.
package tpd_pkg;

    localparam int PACKETS_PER_SEGMENT_DEF = 60;
    localparam int PIXELS_PER_PACKET_DEF   = 80;
    localparam int SEGMENTS_PER_FRAME_DEF  = 4;
    localparam int PACKET_BYTES_DEF        = 164;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 14;
    localparam int INDEX_W = 15;
    localparam int CAUSE_W = 2;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int EXP_W   = 6;
    localparam int SEG_W   = 3;
    localparam int CNT_W   = 16;

    localparam logic [3:0]        DISCARD_NIBBLE       = 4'hf;
    localparam logic [BYTE_W-1:0] SEGMENT_CHECK_PACKET = 8'd20;
    localparam logic [BYTE_W-1:0] NO_PACKET            = 8'd255;
    localparam logic [CNT_W-1:0]  DISCARD_LIMIT_RESET  = 16'd1000;

    typedef enum logic {
        KIND_PIXEL  = 1'b0,
        KIND_RESYNC = 1'b1
    } t_kind;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_BAD_PACKET    = 2'd0,
        CAUSE_SEG_MISMATCH  = 2'd1,
        CAUSE_DISCARD_LIMIT = 2'd2
    } t_cause;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOUR_SEGMENT  = 1'b0,
        CFG_DISCARD_LIMIT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              packet_start;
    } t_item;

    typedef struct packed {
        t_kind              out_kind;
        logic [VALUE_W-1:0] pixel_value;
        logic [INDEX_W-1:0] pixel_index;
        logic               frame_done;
        t_cause             resync_cause;
    } t_result;

endpackage

@@ src/tpd_in_if.sv @@
// Input channel of the deframer: one received byte per beat.
// Depends on tpd_pkg.
interface tpd_in_if import tpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              packet_start;

    modport source (output valid, output rx_byte, output packet_start, input ready);
    modport sink   (input valid, input rx_byte, input packet_start, output ready);
endinterface

@@ src/tpd_out_if.sv @@
// Output channel of the deframer: one pixel or resync result per beat.
// Depends on tpd_pkg.
interface tpd_out_if import tpd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               out_kind;
    logic [VALUE_W-1:0] pixel_value;
    logic [INDEX_W-1:0] pixel_index;
    logic               frame_done;
    logic [CAUSE_W-1:0] resync_cause;

    modport source (output valid, output out_kind, output pixel_value,
                    output pixel_index, output frame_done, output resync_cause,
                    input ready);
    modport sink   (input valid, input out_kind, input pixel_value,
                    input pixel_index, input frame_done, input resync_cause,
                    output ready);
endinterface

@@ src/tpd_in_stage.sv @@
// Input register of the deframer: holds one accepted byte beat until the
// deframing logic takes it. Depends on tpd_pkg.
module tpd_in_stage import tpd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);
    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end
endmodule

@@ src/tpd_deframe.sv @@
// Deframing logic: packet position, header checks, discard counting,
// frame bookkeeping and the configuration registers. Depends on tpd_pkg.
module tpd_deframe import tpd_pkg::*; #(
    parameter int PACKETS_PER_SEGMENT = PACKETS_PER_SEGMENT_DEF,
    parameter int PIXELS_PER_PACKET   = PIXELS_PER_PACKET_DEF,
    parameter int SEGMENTS_PER_FRAME  = SEGMENTS_PER_FRAME_DEF,
    parameter int PACKET_BYTES        = PACKET_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_advance,
    input  t_item                i_item,
    output logic                 o_emit,
    output t_result              o_result
);
    localparam logic [BYTE_W-1:0]  PKT_BYTES   = BYTE_W'(PACKET_BYTES);
    localparam logic [BYTE_W-1:0]  MAX_PKT     = BYTE_W'(PACKETS_PER_SEGMENT - 1);
    localparam logic [EXP_W-1:0]   SEG_PKTS    = EXP_W'(PACKETS_PER_SEGMENT);
    localparam logic [6:0]         PIX_CNT     = 7'(PIXELS_PER_PACKET);
    localparam logic [6:0]         PIX_LAST    = 7'(PIXELS_PER_PACKET - 1);
    localparam logic [SEG_W-1:0]   SEG_CNT     = SEG_W'(SEGMENTS_PER_FRAME);
    localparam logic [INDEX_W-1:0] PKT_PIX     = INDEX_W'(PIXELS_PER_PACKET);
    localparam logic [INDEX_W-1:0] SEG_PIX     =
        INDEX_W'(PACKETS_PER_SEGMENT * PIXELS_PER_PACKET);

    logic             r_four_seg;
    logic [CNT_W-1:0] r_discard_limit;

    logic [BYTE_W-1:0] r_byte_pos,   n_byte_pos;
    logic [EXP_W-1:0]  r_expected,   n_expected;
    logic [SEG_W-1:0]  r_segment,    n_segment;
    logic [CNT_W-1:0]  r_discard,    n_discard;
    logic [BYTE_W-1:0] r_header,     n_header;
    logic              r_accepted,   n_accepted;
    logic [BYTE_W-1:0] r_high,       n_high;

    logic [BYTE_W-1:0]  pos;
    logic [BYTE_W-1:0]  pix_off;
    logic [6:0]         pix;
    logic [CNT_W-1:0]   disc_inc;
    logic [EXP_W-1:0]   exp_inc;
    logic [SEG_W-1:0]   seg_m1;
    logic [INDEX_W-1:0] seg_off;
    logic [INDEX_W-1:0] pkt_off;
    logic [BYTE_W-1:0]  b;

    assign b       = i_item.rx_byte;
    assign pos     = i_item.packet_start ? '0 : r_byte_pos;
    assign pix_off = pos - BYTE_W'(4);
    assign pix     = pix_off[7:1];
    assign exp_inc = r_expected + EXP_W'(1);
    assign seg_m1  = r_segment - SEG_W'(1);
    assign pkt_off = INDEX_W'({{(INDEX_W-EXP_W){1'b0}}, r_expected} * PKT_PIX);

    // The segment offset applies in four-segment mode only, and not for segment zero.
    always_comb begin
        seg_off = '0;
        if (r_four_seg && (r_segment != '0)) begin
            seg_off = INDEX_W'({{(INDEX_W-SEG_W){1'b0}}, seg_m1} * SEG_PIX);
        end
    end

    always_comb begin
        disc_inc = r_discard;
        if (r_discard != '1) begin
            disc_inc = r_discard + CNT_W'(1);
        end
    end

    always_comb begin
        n_byte_pos = (pos < PKT_BYTES) ? pos + BYTE_W'(1) : PKT_BYTES;
        n_expected = r_expected;
        n_segment  = r_segment;
        n_discard  = r_discard;
        n_header   = r_header;
        n_accepted = r_accepted;
        n_high     = r_high;

        o_emit                = 1'b0;
        o_result.out_kind     = KIND_PIXEL;
        o_result.pixel_value  = '0;
        o_result.pixel_index  = '0;
        o_result.frame_done   = 1'b0;
        o_result.resync_cause = CAUSE_BAD_PACKET;

        if (pos == BYTE_W'(0)) begin
            n_header   = b;
            n_accepted = 1'b0;
            if (b[3:0] == DISCARD_NIBBLE) begin
                n_discard = disc_inc;
                if (disc_inc > r_discard_limit) begin
                    n_discard             = '0;
                    o_emit                = 1'b1;
                    o_result.out_kind     = KIND_RESYNC;
                    o_result.resync_cause = CAUSE_DISCARD_LIMIT;
                end
            end
        end else if (pos == BYTE_W'(1)) begin
            if (r_header[3:0] != DISCARD_NIBBLE) begin
                if ((b > MAX_PKT) && (b != NO_PACKET)) begin
                    n_expected            = '0;
                    o_emit                = 1'b1;
                    o_result.out_kind     = KIND_RESYNC;
                    o_result.resync_cause = CAUSE_BAD_PACKET;
                end else if (r_four_seg && (b == SEGMENT_CHECK_PACKET) &&
                             (r_header[7:4] != {1'b0, r_segment})) begin
                    n_expected            = '0;
                    o_emit                = 1'b1;
                    o_result.out_kind     = KIND_RESYNC;
                    o_result.resync_cause = CAUSE_SEG_MISMATCH;
                end else if (b == {{(BYTE_W-EXP_W){1'b0}}, r_expected}) begin
                    n_accepted = 1'b1;
                end
            end
        end else if ((pos >= BYTE_W'(4)) && (pos < PKT_BYTES) && r_accepted &&
                     (pix < PIX_CNT)) begin
            if (!pix_off[0]) begin
                n_high = b;
            end else begin
                o_emit               = 1'b1;
                o_result.pixel_value = {r_high, b[7:2]};
                o_result.pixel_index = INDEX_W'(pix) + pkt_off + seg_off;
                if (pix == PIX_LAST) begin
                    n_accepted = 1'b0;
                    n_expected = exp_inc;
                    if (exp_inc >= SEG_PKTS) begin
                        n_expected = '0;
                        if (r_four_seg) begin
                            if (r_segment >= SEG_CNT) begin
                                n_segment           = SEG_W'(1);
                                o_result.frame_done = 1'b1;
                            end else begin
                                n_segment = r_segment + SEG_W'(1);
                            end
                        end else begin
                            o_result.frame_done = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_seg      <= 1'b1;
            r_discard_limit <= DISCARD_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FOUR_SEGMENT:  r_four_seg      <= i_cfg_data[0];
                CFG_DISCARD_LIMIT: r_discard_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= '0;
            r_expected <= '0;
            r_segment  <= SEG_W'(1);
            r_discard  <= '0;
            r_header   <= '0;
            r_accepted <= 1'b0;
            r_high     <= '0;
        end else if (i_advance) begin
            r_byte_pos <= n_byte_pos;
            r_expected <= n_expected;
            r_segment  <= n_segment;
            r_discard  <= n_discard;
            r_header   <= n_header;
            r_accepted <= n_accepted;
            r_high     <= n_high;
        end
    end
endmodule

@@ src/tpd_out_stage.sv @@
// Result register of the deframer: holds one result beat until the sink
// takes it. Depends on tpd_pkg.
module tpd_out_stage import tpd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);
    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end
endmodule

@@ src/thermal_packet_deframer.sv @@
// Thermal camera SPI packet deframer. A byte's result, if any, passes from the input
// register through the header and pixel logic into the result register, which offers
// it to the sink. Throughput is one byte per cycle, set by the single pass through the
// header and pixel logic between those registers; a result held by the sink stalls the
// input. Synchronous active-low reset: empty stages, expected packet 0, segment 1,
// discard count 0, four-segment mode on, discard limit 1000.
module thermal_packet_deframer import tpd_pkg::*; #(
    parameter int PACKETS_PER_SEGMENT = PACKETS_PER_SEGMENT_DEF,
    parameter int PIXELS_PER_PACKET   = PIXELS_PER_PACKET_DEF,
    parameter int SEGMENTS_PER_FRAME  = SEGMENTS_PER_FRAME_DEF,
    parameter int PACKET_BYTES        = PACKET_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    tpd_in_if.sink               i_in,
    tpd_out_if.source            o_out
);
    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    can_load;
    logic    advance;
    logic    emit;
    t_result result;
    t_result out_result;

    assign in_item.rx_byte      = i_in.rx_byte;
    assign in_item.packet_start = i_in.packet_start;

    // A staged beat moves on only when the result register has room for it.
    assign advance = stage_valid && can_load;

    tpd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_item    (in_item),
        .o_ready   (i_in.ready),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    tpd_deframe #(
        .PACKETS_PER_SEGMENT (PACKETS_PER_SEGMENT),
        .PIXELS_PER_PACKET   (PIXELS_PER_PACKET),
        .SEGMENTS_PER_FRAME  (SEGMENTS_PER_FRAME),
        .PACKET_BYTES        (PACKET_BYTES)
    ) u_deframe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (advance),
        .i_item      (stage_item),
        .o_emit      (emit),
        .o_result    (result)
    );

    tpd_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && emit),
        .i_result   (result),
        .o_can_load (can_load),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_result   (out_result)
    );

    assign o_out.out_kind     = out_result.out_kind;
    assign o_out.pixel_value  = out_result.pixel_value;
    assign o_out.pixel_index  = out_result.pixel_index;
    assign o_out.frame_done   = out_result.frame_done;
    assign o_out.resync_cause = out_result.resync_cause;
endmodule
